// File: hw/rtl/polyline_stroke_triangulator_macros.svh
// Assertion macros for the polyline stroke triangulator.
`ifndef POLYLINE_STROKE_TRIANGULATOR_MACROS_SVH
`define POLYLINE_STROKE_TRIANGULATOR_MACROS_SVH
// Implication checked at every rising clock edge, off during reset.
`define PST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, off during reset.
`define PST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: hw/rtl/pst_pkg.sv
// Package: constants, types and helpers of the polyline stroke triangulator.
package pst_pkg;
   localparam int COORD_BITS_DEF    = 16;
   localparam int DIR_FRAC_BITS_DEF = 14;
   localparam int IN_BITS           = 16;
   localparam int CLR_BITS          = 24;
   localparam int LW_BITS           = 8;
   localparam int CSR_IDX_BITS      = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STROKE_COLOR = 1'b1;

   localparam logic [LW_BITS-1:0]  LINE_WIDTH_RST   = 8'd2;
   localparam logic [CLR_BITS-1:0] STROKE_COLOR_RST = 24'hFFFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQRT,
      ST_DIVX,
      ST_DIVY,
      ST_SCALE,
      ST_EMIT,
      ST_WAIT
   } state_type;
endpackage

// File: hw/rtl/pst_if.sv
// Interfaces: input vertex, triangle result and register write channels.
interface pst_req_if #(parameter int CoordBits = pst_pkg::IN_BITS);
   logic                        valid;
   logic                        ready;
   logic signed [CoordBits-1:0] point_x;
   logic signed [CoordBits-1:0] point_y;
   logic                        starts_line;
   modport source (output valid, point_x, point_y, starts_line, input ready);
   modport sink (input valid, point_x, point_y, starts_line, output ready);
endinterface

interface pst_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   vert0_x;
   logic signed [15:0]   vert0_y;
   logic signed [15:0]   vert1_x;
   logic signed [15:0]   vert1_y;
   logic signed [15:0]   vert2_x;
   logic signed [15:0]   vert2_y;
   logic [23:0]          tri_color;
   logic                 last_of_run;
   modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                   tri_color, last_of_run, input ready);
   modport sink (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                 tri_color, last_of_run, output ready);
endinterface

interface pst_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/pst_divsqrt.sv
// Shared restoring unit: one bit per cycle of integer square root or division.
module pst_divsqrt #(
   parameter int W = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         is_sqrt,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] result
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  sh_ff, sh_in;
   logic [W-1:0]  den_ff, den_in;
   logic          sq_ff, sq_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W+1:0]  trial;
   logic [W+1:0]  part;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      sq_in   = sq_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      part    = '0;
      if (start) begin
         rem_in  = '0;
         quo_in  = '0;
         sh_in   = num;
         den_in  = den;
         sq_in   = is_sqrt;
         cnt_in  = is_sqrt ? CW'(W / 2) : CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sq_ff) begin
            part  = {rem_ff, sh_ff[W-1 -: 2]};
            trial = part - {quo_ff, 2'b01};
            sh_in = sh_ff << 2;
         end else begin
            part  = {1'b0, rem_ff, sh_ff[W-1]};
            trial = part - {2'b00, den_ff};
            sh_in = sh_ff << 1;
         end
         if (!trial[W+1]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = part[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      sq_ff  <= sq_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;
endmodule

// File: hw/rtl/polyline_stroke_triangulator.sv
// A segment vertex is normalized, then run through the sqrt and the x and y divides
// on the shared unit, scaled, and emits triangles; zero length skips sqrt and divides.
// A new vertex is taken only in idle, after the last triangle of the one before, and
// output stalls hold the emission; a line-start vertex is only stored, emits no triangle.
// Synchronous reset clears history, state and registers (width 2, color white).
module polyline_stroke_triangulator #(
   parameter int DIR_FRAC_BITS = pst_pkg::DIR_FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pst_req_if.sink       req,
   pst_rsp_if.source     rsp,
   pst_csr_if.sink       csr
);
   localparam int COORD_BITS = pst_pkg::COORD_BITS_DEF;
   localparam int SW = 64;
   localparam int UW = DIR_FRAC_BITS + 2;
   localparam int WW = 20;

   pst_pkg::state_type st_ff, st_in;

   logic [pst_pkg::LW_BITS-1:0]  lw_ff, lw_in;
   logic [pst_pkg::CLR_BITS-1:0] clr_ff, clr_in;
   logic signed [15:0] ppx_ff, ppx_in, ppy_ff, ppy_in, cx_ff, cx_in, cy_ff, cy_in;
   logic signed [UW-1:0] pdx_ff, pdx_in, pdy_ff, pdy_in, ux_ff, ux_in, uy_ff, uy_in;
   logic have_pt_ff, have_pt_in, have_dir_ff, have_dir_in;
   logic [16:0] ax_ff, ax_in, ay_ff, ay_in;
   logic sx_ff, sx_in, sy_ff, sy_in;
   logic [SW-1:0] len_ff, len_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] k_ff, k_in;
   logic signed [WW-1:0] ox_ff, ox_in, oy_ff, oy_in, qx_ff, qx_in, qy_ff, qy_in;
   logic rv_ff, rv_in;
   logic signed [15:0] o_ff [6], o_in [6];
   logic last_ff, last_in;

   logic          du_start, du_sqrt, du_done;
   logic [SW-1:0] du_num, du_den, du_res;

   logic signed [16:0] dx, dy;
   logic [16:0] m;
   logic [UW-1:0] qcap;
   logic signed [WW-1:0] sc_x, sc_y, sc_qx, sc_qy;
   logic signed [WW-1:0] cz [6];
   logic [33:0] sumsq;

   pst_divsqrt #(.W(SW)) u_du (
      .clock, .reset, .start(du_start), .is_sqrt(du_sqrt),
      .num(du_num), .den(du_den), .done(du_done), .result(du_res)
   );

   function automatic logic signed [WW-1:0] scale_f(input logic signed [UW-1:0] n,
                                                     input logic [7:0] w);
      logic [UW-1:0] mg;
      logic [UW+11:0] p;
      logic [WW-1:0] r;
      mg = n[UW-1] ? UW'(-n) : UW'(n);
      p  = (UW+12)'(mg) * (UW+12)'({w, 3'b000}) + ((UW+12)'(1) << (DIR_FRAC_BITS - 1));
      r  = WW'(p >> DIR_FRAC_BITS);
      return n[UW-1] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [15:0] sat_f(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] hi, lo;
      hi = WW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
      lo = -hi - WW'(1);
      if (v > hi) return hi[15:0];
      if (v < lo) return lo[15:0];
      return v[15:0];
   endfunction

   assign csr.ready = 1'b1;
   assign req.ready = (st_ff == pst_pkg::ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.vert0_x = o_ff[0];
   assign rsp.vert0_y = o_ff[1];
   assign rsp.vert1_x = o_ff[2];
   assign rsp.vert1_y = o_ff[3];
   assign rsp.vert2_x = o_ff[4];
   assign rsp.vert2_y = o_ff[5];
   assign rsp.tri_color = clr_ff;
   assign rsp.last_of_run = last_ff;

   assign dx = 17'(cx_ff) - 17'(ppx_ff);
   assign dy = 17'(cy_ff) - 17'(ppy_ff);
   assign m  = ax_ff > ay_ff ? ax_ff : ay_ff;
   assign qcap = UW'(1) << DIR_FRAC_BITS;
   assign sumsq = 34'(ax_ff) * 34'(ax_ff) + 34'(ay_ff) * 34'(ay_ff);
   assign sc_x  = scale_f(-uy_ff, lw_ff);
   assign sc_y  = scale_f(ux_ff, lw_ff);
   assign sc_qx = scale_f(-pdy_ff, lw_ff);
   assign sc_qy = scale_f(pdx_ff, lw_ff);

   always_comb begin
      st_in = st_ff; lw_in = lw_ff; clr_in = clr_ff;
      ppx_in = ppx_ff; ppy_in = ppy_ff; cx_in = cx_ff; cy_in = cy_ff;
      pdx_in = pdx_ff; pdy_in = pdy_ff; ux_in = ux_ff; uy_in = uy_ff;
      have_pt_in = have_pt_ff; have_dir_in = have_dir_ff;
      ax_in = ax_ff; ay_in = ay_ff; sx_in = sx_ff; sy_in = sy_ff;
      len_in = len_ff; step_in = step_ff; k_in = k_ff;
      ox_in = ox_ff; oy_in = oy_ff; qx_in = qx_ff; qy_in = qy_ff;
      rv_in = rv_ff; last_in = last_ff;
      for (int i = 0; i < 6; i++) o_in[i] = o_ff[i];
      for (int i = 0; i < 6; i++) cz[i] = '0;
      du_start = 1'b0; du_sqrt = 1'b0; du_num = '0; du_den = '0;

      if (csr.valid) begin
         case (csr.index[pst_pkg::CSR_IDX_BITS-1:0] == pst_pkg::CSR_LINE_WIDTH)
            1'b1: if (csr.index[7:1] == '0) lw_in = csr.data[7:0];
            default: if (csr.index[7:1] == '0) clr_in = csr.data[23:0];
         endcase
      end
      if (rsp.valid && rsp.ready) rv_in = 1'b0;

      case (st_ff)
         pst_pkg::ST_IDLE: begin
            if (req.valid) begin
               if (req.starts_line || !have_pt_ff) begin
                  ppx_in = req.point_x; ppy_in = req.point_y;
                  pdx_in = '0; pdy_in = '0;
                  have_pt_in = 1'b1; have_dir_in = 1'b0;
               end else begin
                  cx_in = req.point_x; cy_in = req.point_y;
                  st_in = pst_pkg::ST_NORM;
                  step_in = '0;
               end
            end
         end
         pst_pkg::ST_NORM: begin
            if (step_ff == 4'd0) begin
               sx_in = dx[16]; sy_in = dy[16];
               ax_in = dx[16] ? 17'(-dx) : 17'(dx);
               ay_in = dy[16] ? 17'(-dy) : 17'(dy);
               step_in = 4'd1;
            end else if (m == '0) begin
               ux_in = '0; uy_in = '0;
               st_in = pst_pkg::ST_SCALE;
            end else if (m[16:15] != 2'b00) begin
               ax_in = ax_ff >> 1; ay_in = ay_ff >> 1;
            end else if (!m[14]) begin
               ax_in = ax_ff << 1; ay_in = ay_ff << 1;
            end else begin
               du_start = 1'b1; du_sqrt = 1'b1;
               du_num = SW'(sumsq) << 32;
               st_in = pst_pkg::ST_SQRT;
            end
         end
         pst_pkg::ST_SQRT: begin
            if (du_done) begin
               len_in = du_res;
               du_start = 1'b1;
               du_num = (SW'(ax_ff) << (DIR_FRAC_BITS + 16)) + (du_res >> 1);
               du_den = du_res;
               st_in = pst_pkg::ST_DIVX;
            end
         end
         pst_pkg::ST_DIVX: begin
            if (du_done) begin
               ux_in = du_res > SW'(qcap) ? qcap : du_res[UW-1:0];
               if (sx_ff) ux_in = -ux_in;
               du_start = 1'b1;
               du_num = (SW'(ay_ff) << (DIR_FRAC_BITS + 16)) + (len_ff >> 1);
               du_den = len_ff;
               st_in = pst_pkg::ST_DIVY;
            end
         end
         pst_pkg::ST_DIVY: begin
            if (du_done) begin
               uy_in = du_res > SW'(qcap) ? qcap : du_res[UW-1:0];
               if (sy_ff) uy_in = -uy_in;
               st_in = pst_pkg::ST_SCALE;
            end
         end
         pst_pkg::ST_SCALE: begin
            ox_in = sc_x; oy_in = sc_y; qx_in = sc_qx; qy_in = sc_qy;
            k_in = have_dir_ff ? 2'd0 : 2'd2;
            st_in = pst_pkg::ST_EMIT;
         end
         pst_pkg::ST_EMIT: begin
            if (!rv_ff || rsp.ready) begin
               case (k_ff)
                  2'd0: begin
                     cz[0] = WW'(ppx_ff) + qx_ff; cz[1] = WW'(ppy_ff) + qy_ff;
                     cz[2] = WW'(ppx_ff) + ox_ff; cz[3] = WW'(ppy_ff) + oy_ff;
                     cz[4] = WW'(ppx_ff);         cz[5] = WW'(ppy_ff);
                  end
                  2'd1: begin
                     cz[0] = WW'(ppx_ff) - qx_ff; cz[1] = WW'(ppy_ff) - qy_ff;
                     cz[2] = WW'(ppx_ff) - ox_ff; cz[3] = WW'(ppy_ff) - oy_ff;
                     cz[4] = WW'(ppx_ff);         cz[5] = WW'(ppy_ff);
                  end
                  2'd2: begin
                     cz[0] = WW'(ppx_ff) + ox_ff; cz[1] = WW'(ppy_ff) + oy_ff;
                     cz[2] = WW'(ppx_ff) - ox_ff; cz[3] = WW'(ppy_ff) - oy_ff;
                     cz[4] = WW'(cx_ff) + ox_ff;  cz[5] = WW'(cy_ff) + oy_ff;
                  end
                  default: begin
                     cz[0] = WW'(ppx_ff) - ox_ff; cz[1] = WW'(ppy_ff) - oy_ff;
                     cz[2] = WW'(cx_ff) + ox_ff;  cz[3] = WW'(cy_ff) + oy_ff;
                     cz[4] = WW'(cx_ff) - ox_ff;  cz[5] = WW'(cy_ff) - oy_ff;
                  end
               endcase
               for (int i = 0; i < 6; i++) o_in[i] = sat_f(cz[i]);
               rv_in = 1'b1;
               last_in = (k_ff == 2'd3);
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) st_in = pst_pkg::ST_WAIT;
            end
         end
         pst_pkg::ST_WAIT: begin
            ppx_in = cx_ff; ppy_in = cy_ff;
            pdx_in = ux_ff; pdy_in = uy_ff;
            have_dir_in = 1'b1;
            st_in = pst_pkg::ST_IDLE;
         end
         default: st_in = pst_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= pst_pkg::ST_IDLE;
         lw_ff <= pst_pkg::LINE_WIDTH_RST;
         clr_ff <= pst_pkg::STROKE_COLOR_RST;
         ppx_ff <= '0; ppy_ff <= '0; pdx_ff <= '0; pdy_ff <= '0;
         have_pt_ff <= 1'b0; have_dir_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         lw_ff <= lw_in;
         clr_ff <= clr_in;
         ppx_ff <= ppx_in; ppy_ff <= ppy_in; pdx_ff <= pdx_in; pdy_ff <= pdy_in;
         have_pt_ff <= have_pt_in; have_dir_ff <= have_dir_in;
         rv_ff <= rv_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; ux_ff <= ux_in; uy_ff <= uy_in;
      ax_ff <= ax_in; ay_ff <= ay_in; sx_ff <= sx_in; sy_ff <= sy_in;
      len_ff <= len_in; step_ff <= step_in; k_ff <= k_in;
      ox_ff <= ox_in; oy_ff <= oy_in; qx_ff <= qx_in; qy_ff <= qy_in;
      last_ff <= last_in;
      for (int i = 0; i < 6; i++) o_ff[i] <= o_in[i];
   end
endmodule

// File: hw/rtl/pst_checker.sv
// Port checker for the polyline stroke triangulator, bound to the top level.
`include "polyline_stroke_triangulator_macros.svh"
module pst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_last_of_run,
   input logic [23:0] rsp_tri_color
);
   `PST_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `PST_ASSERT_NXT(a_hold_last, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_last_of_run), "last changed")
   `PST_ASSERT_NXT(a_hold_color, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_tri_color), "color changed")
   `PST_ASSERT_IMP(a_ready_known, clock, reset, req_valid, !$isunknown(req_ready), "ready unknown")
endmodule

bind polyline_stroke_triangulator pst_checker u_pst_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_last_of_run(rsp.last_of_run), .rsp_tri_color(rsp.tri_color)
);
